// ===== hw/rtl/nsa_pkg.sv =====
// ----------------------------------------------------------------------------
// nsa_pkg
// Shared types, constants, microcode and sigmoid helpers for the neuron block.
// ----------------------------------------------------------------------------
package nsa_pkg;

   localparam int NUM_CONNECTORS_DEF   = 8;
   localparam int SIGMOID_SEGMENTS_DEF = 16;

   localparam int VALUE_W = 16;
   localparam int DER_W   = 9;
   localparam int CONN_W  = 3;
   localparam int REQ_W   = 2;
   localparam int STEP_W  = 4;
   localparam int STEPS   = 1 << STEP_W;

   // register index, taken from byte address bit 2
   localparam logic REG_ACTIVATION_MODE = 1'b0;

   typedef enum logic [REQ_W-1:0] {
      REQ_STORE = 2'd0,
      REQ_FIRE  = 2'd1,
      REQ_CLEAR = 2'd2
   } req_code_type;

   typedef enum logic [1:0] {
      MODE_IDENTITY = 2'd0,
      MODE_SIGMOID  = 2'd1,
      MODE_RAMP     = 2'd2,
      MODE_LINEAR   = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_IDLE,
      OP_SUM_INIT,
      OP_SUM_STEP,
      OP_SAT,
      OP_SEG,
      OP_MUL_SLOPE,
      OP_DIV_STEP,
      OP_G,
      OP_MUL_DER,
      OP_DER,
      OP_LIN,
      OP_OUT
   } op_type;

   typedef enum logic [2:0] {
      COND_NONE,
      COND_ALWAYS,
      COND_FIRE,
      COND_LAST_SLOT,
      COND_LINEAR,
      COND_DIV_LAST,
      COND_OUT_FREE
   } cond_type;

   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_IDLE     = 4'd0;
   localparam step_type STEP_SUM_INIT = 4'd1;
   localparam step_type STEP_SUM      = 4'd2;
   localparam step_type STEP_SAT      = 4'd3;
   localparam step_type STEP_SEG      = 4'd4;
   localparam step_type STEP_MUL1     = 4'd5;
   localparam step_type STEP_DIV      = 4'd6;
   localparam step_type STEP_G        = 4'd7;
   localparam step_type STEP_MUL2     = 4'd8;
   localparam step_type STEP_DER      = 4'd9;
   localparam step_type STEP_LIN      = 4'd10;
   localparam step_type STEP_OUT      = 4'd11;

   // taken cond -> target; otherwise hold stays, else falls through
   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
      logic     hold;
   } uword_type;

   typedef struct packed {
      logic fire_go;
      logic last_slot;
      logic div_last;
      logic linear;
      logic out_free;
   } status_type;

   localparam uword_type UCODE [STEPS] = '{
      '{OP_IDLE,      COND_FIRE,      STEP_SUM_INIT, 1'b1},
      '{OP_SUM_INIT,  COND_NONE,      STEP_IDLE,     1'b0},
      '{OP_SUM_STEP,  COND_LAST_SLOT, STEP_SAT,      1'b1},
      '{OP_SAT,       COND_LINEAR,    STEP_LIN,      1'b0},
      '{OP_SEG,       COND_NONE,      STEP_IDLE,     1'b0},
      '{OP_MUL_SLOPE, COND_NONE,      STEP_IDLE,     1'b0},
      '{OP_DIV_STEP,  COND_DIV_LAST,  STEP_G,        1'b1},
      '{OP_G,         COND_NONE,      STEP_IDLE,     1'b0},
      '{OP_MUL_DER,   COND_NONE,      STEP_IDLE,     1'b0},
      '{OP_DER,       COND_ALWAYS,    STEP_OUT,      1'b0},
      '{OP_LIN,       COND_NONE,      STEP_IDLE,     1'b0},
      '{OP_OUT,       COND_OUT_FREE,  STEP_IDLE,     1'b1},
      '{OP_NOP,       COND_ALWAYS,    STEP_IDLE,     1'b0},
      '{OP_NOP,       COND_ALWAYS,    STEP_IDLE,     1'b0},
      '{OP_NOP,       COND_ALWAYS,    STEP_IDLE,     1'b0},
      '{OP_NOP,       COND_ALWAYS,    STEP_IDLE,     1'b0}
   };

   // sigmoid(0.5*i) in units of 1/65536
   localparam int SIG_HALF [17] = '{
      32768, 40793, 47911, 53580, 57724, 60565, 62428, 63615, 64357,
      64816, 65097, 65269, 65374, 65438, 65476, 65500, 65514
   };

   // fine interpolated sigmoid at a Q8.8 point, elaboration only
   function automatic int fine_sig(input int x);
      int a;
      int i;
      int f;
      int v;
      a = (x < 0) ? -x : x;
      if (a > 2048) a = 2048;
      i = a >> 7;
      f = a & 127;
      if (i >= 16) begin
         v = SIG_HALF[16];
      end else begin
         v = SIG_HALF[i] + (((SIG_HALF[i+1] - SIG_HALF[i]) * f + 64) >> 7);
      end
      return (x < 0) ? 65536 - v : v;
   endfunction

endpackage

// ===== hw/rtl/nsa_channels.sv =====
// ----------------------------------------------------------------------------
// nsa channels
// Valid/ready request and response channels of the neuron block.
// ----------------------------------------------------------------------------
interface nsa_req_if;
   logic                                valid;
   logic                                ready;
   logic [nsa_pkg::REQ_W-1:0]           req_type;
   logic [nsa_pkg::CONN_W-1:0]          connector;
   logic signed [nsa_pkg::VALUE_W-1:0]  input_value;

   modport source (output valid, req_type, connector, input_value, input ready);
   modport sink   (input valid, req_type, connector, input_value, output ready);
endinterface

interface nsa_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [nsa_pkg::VALUE_W-1:0]  activation;
   logic [nsa_pkg::DER_W-1:0]           derivative;
   logic signed [nsa_pkg::VALUE_W-1:0]  net_sum;
   logic                                saturated;

   modport source (output valid, activation, derivative, net_sum, saturated, input ready);
   modport sink   (input valid, activation, derivative, net_sum, saturated, output ready);
endinterface

// ===== hw/rtl/nsa_seq.sv =====
// ----------------------------------------------------------------------------
// nsa_seq
// Microcode sequencer: step counter, control ROM and conditional jumps.
// ----------------------------------------------------------------------------
module nsa_seq (
   input  logic                clock,
   input  logic                reset,
   input  nsa_pkg::status_type status,
   output nsa_pkg::uword_type  ctrl
);

   nsa_pkg::step_type  pc_ff, pc_in;
   nsa_pkg::uword_type uw;
   logic               take;

   always_comb begin
      uw = nsa_pkg::UCODE[pc_ff];
      unique case (uw.cond)
         nsa_pkg::COND_NONE:      take = 1'b0;
         nsa_pkg::COND_ALWAYS:    take = 1'b1;
         nsa_pkg::COND_FIRE:      take = status.fire_go;
         nsa_pkg::COND_LAST_SLOT: take = status.last_slot;
         nsa_pkg::COND_LINEAR:    take = status.linear;
         nsa_pkg::COND_DIV_LAST:  take = status.div_last;
         nsa_pkg::COND_OUT_FREE:  take = status.out_free;
         default:                 take = 1'b1;
      endcase
      if (take) begin
         pc_in = uw.target;
      end else if (uw.hold) begin
         pc_in = pc_ff;
      end else begin
         pc_in = pc_ff + nsa_pkg::step_type'(1);
      end
      ctrl = uw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= nsa_pkg::STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// ===== hw/rtl/nsa_dp.sv =====
// ----------------------------------------------------------------------------
// nsa_dp
// Datapath: slot memory, accumulator, sigmoid segment tables, shared
// multiplier, radix-2 divider and the response register.
// ----------------------------------------------------------------------------
module nsa_dp #(
   parameter int NUM_CONNECTORS   = nsa_pkg::NUM_CONNECTORS_DEF,
   parameter int SIGMOID_SEGMENTS = nsa_pkg::SIGMOID_SEGMENTS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  nsa_pkg::uword_type  ctrl,
   input  nsa_pkg::mode_type   mode,
   nsa_req_if.sink             req_ch,
   nsa_rsp_if.source           rsp_ch,
   output nsa_pkg::status_type status
);

   localparam int IDX_W  = (NUM_CONNECTORS > 1) ? $clog2(NUM_CONNECTORS) : 1;
   localparam int DEPTH  = 1 << IDX_W;
   localparam int SUM_W  = IDX_W + 17;
   localparam int AW     = (IDX_W > nsa_pkg::CONN_W) ? IDX_W : nsa_pkg::CONN_W;
   localparam int KW     = $clog2(SIGMOID_SEGMENTS + 1);
   localparam int DIV_Q  = 16;
   localparam int REM_W  = 27;
   localparam logic [7:0] K_MAX = 8'(SIGMOID_SEGMENTS - 1);
   localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'(32767);
   localparam logic signed [SUM_W-1:0] SUM_LO = -SUM_W'(32768);

   // segment tables
   logic signed [12:0] pos_tab [SIGMOID_SEGMENTS+1];
   logic [15:0]        val_tab [SIGMOID_SEGMENTS+1];

   for (genvar k = 0; k <= SIGMOID_SEGMENTS; k++) begin : g_seg
      localparam int P = (4096 * k) / SIGMOID_SEGMENTS - 2048;
      localparam int V = nsa_pkg::fine_sig(P);
      assign pos_tab[k] = 13'(P);
      assign val_tab[k] = 16'(V);
   end

   logic signed [15:0] slot_mem [DEPTH];
   logic signed [15:0] rd_ff;
   logic               fil_ff;

   logic [DEPTH-1:0]         filled_ff, filled_in;
   logic [IDX_W-1:0]         cnt_ff, cnt_in;
   logic signed [SUM_W-1:0]  acc_ff, acc_in;
   logic signed [15:0]       net_ff, net_in;
   logic                     sat_ff, sat_in;
   logic [15:0]              v0_ff, v0_in;
   logic [15:0]              dv_ff, dv_in;
   logic [10:0]              dx_ff, dx_in;
   logic [10:0]              den_ff, den_in;
   logic [REM_W-1:0]         rem_ff, rem_in;
   logic [REM_W-1:0]         dsh_ff, dsh_in;
   logic [DIV_Q-1:0]         q_ff, q_in;
   logic [3:0]               dcnt_ff, dcnt_in;
   logic [15:0]              g_ff, g_in;
   logic [32:0]              prod_ff, prod_in;
   logic signed [15:0]       act_ff, act_in;
   logic [8:0]               der_ff, der_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]       out_act_ff, out_act_in;
   logic [8:0]               out_der_ff, out_der_in;
   logic signed [15:0]       out_net_ff, out_net_in;
   logic                     out_sat_ff, out_sat_in;

   logic                     req_go;
   logic                     wr_en;
   logic [AW-1:0]            conn_ext;
   logic [IDX_W-1:0]         wr_addr, rd_addr;
   logic signed [12:0]       xc;
   logic [12:0]              u;
   logic [19:0]              seg_prod;
   logic [7:0]               k_sat;
   logic [KW-1:0]            k0, k1;
   logic signed [12:0]       p_diff, x_diff;
   logic [15:0]              mul_a;
   logic [16:0]              mul_b;
   logic [32:0]              mul_p;
   logic [REM_W:0]           trial;
   logic [16:0]              g_round;
   logic [32:0]              der_round;
   logic                     out_free;
   logic                     load_out;

   assign req_ch.ready = (ctrl.op == nsa_pkg::OP_IDLE);

   always_comb begin
      req_go   = req_ch.valid && req_ch.ready;
      conn_ext = AW'(req_ch.connector);
      wr_addr  = conn_ext[IDX_W-1:0];
      wr_en    = req_go && (req_ch.req_type == nsa_pkg::REQ_STORE)
                 && (int'(req_ch.connector) < NUM_CONNECTORS);
      rd_addr  = (ctrl.op == nsa_pkg::OP_SUM_INIT) ? '0 : cnt_ff + IDX_W'(1);

      // sigmoid segment select
      if (net_ff > 16'sd2048) begin
         xc = 13'sd2048;
      end else if (net_ff < -16'sd2048) begin
         xc = -13'sd2048;
      end else begin
         xc = 13'(net_ff);
      end
      u        = unsigned'(xc + 13'sd2048);
      seg_prod = 20'(u) * 20'(SIGMOID_SEGMENTS);
      k_sat    = (seg_prod[19:12] > K_MAX) ? K_MAX : seg_prod[19:12];
      k0       = k_sat[KW-1:0];
      k1       = KW'(k_sat + 8'd1);
      p_diff   = pos_tab[k1] - pos_tab[k0];
      x_diff   = xc - pos_tab[k0];

      // shared multiplier
      if (ctrl.op == nsa_pkg::OP_MUL_DER) begin
         mul_a = g_ff;
         mul_b = 17'h10000 - 17'(g_ff);
      end else begin
         mul_a = dv_ff;
         mul_b = 17'(dx_ff);
      end
      mul_p = 33'(mul_a) * 33'(mul_b);

      trial     = {1'b0, rem_ff} - {1'b0, dsh_ff};
      g_round   = 17'(g_ff) + 17'd128;
      der_round = prod_ff + 33'h800000;

      out_free = !rsp_valid_ff || rsp_ch.ready;
      load_out = (ctrl.op == nsa_pkg::OP_OUT) && out_free;

      status.fire_go   = req_go && (req_ch.req_type == nsa_pkg::REQ_FIRE);
      status.last_slot = (int'(cnt_ff) == NUM_CONNECTORS - 1);
      status.div_last  = (dcnt_ff == 4'(DIV_Q - 1));
      status.linear    = (mode != nsa_pkg::MODE_SIGMOID);
      status.out_free  = out_free;
   end

   always_comb begin
      filled_in = filled_ff;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      net_in    = net_ff;
      sat_in    = sat_ff;
      v0_in     = v0_ff;
      dv_in     = dv_ff;
      dx_in     = dx_ff;
      den_in    = den_ff;
      rem_in    = rem_ff;
      dsh_in    = dsh_ff;
      q_in      = q_ff;
      dcnt_in   = dcnt_ff;
      g_in      = g_ff;
      prod_in   = prod_ff;
      act_in    = act_ff;
      der_in    = der_ff;

      unique case (ctrl.op)
         nsa_pkg::OP_IDLE: begin
            if (wr_en) begin
               filled_in[wr_addr] = 1'b1;
            end
            if (req_go && (req_ch.req_type == nsa_pkg::REQ_CLEAR)) begin
               filled_in = '0;
            end
         end
         nsa_pkg::OP_SUM_INIT: begin
            acc_in = '0;
            cnt_in = '0;
         end
         nsa_pkg::OP_SUM_STEP: begin
            if (fil_ff) begin
               acc_in = acc_ff + SUM_W'(rd_ff);
            end
            cnt_in = cnt_ff + IDX_W'(1);
         end
         nsa_pkg::OP_SAT: begin
            if (acc_ff > SUM_HI) begin
               net_in = 16'sh7fff;
               sat_in = 1'b1;
            end else if (acc_ff < SUM_LO) begin
               net_in = -16'sh8000;
               sat_in = 1'b1;
            end else begin
               net_in = acc_ff[15:0];
               sat_in = 1'b0;
            end
         end
         nsa_pkg::OP_SEG: begin
            v0_in  = val_tab[k0];
            dv_in  = val_tab[k1] - val_tab[k0];
            dx_in  = x_diff[10:0];
            den_in = p_diff[10:0];
         end
         nsa_pkg::OP_MUL_SLOPE: begin
            rem_in  = mul_p[REM_W-1:0];
            dsh_in  = REM_W'(den_ff) << (DIV_Q - 1);
            q_in    = '0;
            dcnt_in = '0;
         end
         nsa_pkg::OP_DIV_STEP: begin
            if (!trial[REM_W]) begin
               rem_in = trial[REM_W-1:0];
            end
            q_in    = {q_ff[DIV_Q-2:0], !trial[REM_W]};
            dsh_in  = dsh_ff >> 1;
            dcnt_in = dcnt_ff + 4'd1;
         end
         nsa_pkg::OP_G: begin
            g_in = v0_ff + q_ff;
         end
         nsa_pkg::OP_MUL_DER: begin
            prod_in = mul_p;
            act_in  = signed'({7'd0, g_round[16:8]});
         end
         nsa_pkg::OP_DER: begin
            der_in = der_round[32:24];
         end
         nsa_pkg::OP_LIN: begin
            case (mode)
               nsa_pkg::MODE_RAMP: begin
                  act_in = net_ff[15] ? 16'sd0 : (net_ff >>> 1);
                  der_in = net_ff[15] ? 9'd0 : 9'd128;
               end
               nsa_pkg::MODE_LINEAR: begin
                  act_in = net_ff >>> 1;
                  der_in = 9'd128;
               end
               default: begin
                  act_in = net_ff;
                  der_in = 9'd256;
               end
            endcase
         end
         default: begin
         end
      endcase

      rsp_valid_in = (rsp_valid_ff && !rsp_ch.ready) || load_out;
      out_act_in   = load_out ? act_ff : out_act_ff;
      out_der_in   = load_out ? der_ff : out_der_ff;
      out_net_in   = load_out ? net_ff : out_net_ff;
      out_sat_in   = load_out ? sat_ff : out_sat_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= req_ch.input_value;
      end
      rd_ff  <= slot_mem[rd_addr];
      fil_ff <= filled_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         filled_ff    <= filled_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      acc_ff     <= acc_in;
      net_ff     <= net_in;
      sat_ff     <= sat_in;
      v0_ff      <= v0_in;
      dv_ff      <= dv_in;
      dx_ff      <= dx_in;
      den_ff     <= den_in;
      rem_ff     <= rem_in;
      dsh_ff     <= dsh_in;
      q_ff       <= q_in;
      dcnt_ff    <= dcnt_in;
      g_ff       <= g_in;
      prod_ff    <= prod_in;
      act_ff     <= act_in;
      der_ff     <= der_in;
      out_act_ff <= out_act_in;
      out_der_ff <= out_der_in;
      out_net_ff <= out_net_in;
      out_sat_ff <= out_sat_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.activation = out_act_ff;
   assign rsp_ch.derivative = out_der_ff;
   assign rsp_ch.net_sum    = out_net_ff;
   assign rsp_ch.saturated  = out_sat_ff;

endmodule

// ===== hw/rtl/neuron_sum_and_activation.sv =====
// ----------------------------------------------------------------------------
// neuron_sum_and_activation
// Single neuron: store, clear and fire requests under a microcoded sequencer.
// ----------------------------------------------------------------------------
// Store, clear and unused requests are taken in the idle step, which holds.
// Fire: the slot walk uses one adder and the sum is saturated; identity, ramp and
// damped linear then take the linear step, and the sigmoid slope goes through a
// 16-step radix-2 divider after the segment and slope multiply steps.
// The next request is taken in the idle step after the response is registered.
// Synchronous reset empties all slots, drops the response and sets sigmoid mode.
module neuron_sum_and_activation #(
   parameter int NUM_CONNECTORS   = nsa_pkg::NUM_CONNECTORS_DEF,
   parameter int SIGMOID_SEGMENTS = nsa_pkg::SIGMOID_SEGMENTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   nsa_req_if.sink     req_ch,
   nsa_rsp_if.source   rsp_ch
);

   nsa_pkg::mode_type   mode_ff, mode_in;
   nsa_pkg::uword_type  ctrl;
   nsa_pkg::status_type status;
   logic                mode_sel;

   always_comb begin
      mode_sel = (csr_paddr[2] == nsa_pkg::REG_ACTIVATION_MODE);
      mode_in  = mode_ff;
      if (csr_psel && csr_penable && csr_pwrite && mode_sel) begin
         mode_in = nsa_pkg::mode_type'(csr_pwdata[1:0]);
      end
      csr_prdata = mode_sel ? {30'd0, mode_ff} : 32'd0;
      csr_pready = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= nsa_pkg::MODE_SIGMOID;
      end else begin
         mode_ff <= mode_in;
      end
   end

   nsa_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   nsa_dp #(
      .NUM_CONNECTORS   (NUM_CONNECTORS),
      .SIGMOID_SEGMENTS (SIGMOID_SEGMENTS)
   ) u_dp (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .mode   (mode_ff),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .status (status)
   );

endmodule

// ===== hw/rtl/nsa_check.sv =====
// ----------------------------------------------------------------------------
// nsa_check
// Port-level assertions for the neuron block, bound to the top level.
// ----------------------------------------------------------------------------
module nsa_check (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_activation,
   input logic [8:0]  rsp_derivative,
   input logic [15:0] rsp_net_sum,
   input logic        rsp_saturated
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_activation)
         && $stable(rsp_derivative) && $stable(rsp_net_sum) && $stable(rsp_saturated))
      else $error("stalled response changed");

   a_der_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_derivative <= 9'd256)
      else $error("derivative above one");

   a_sat_clip: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> rsp_net_sum == 16'h7fff || rsp_net_sum == 16'h8000)
      else $error("saturated without clipped sum");

endmodule

bind neuron_sum_and_activation nsa_check u_nsa_check (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_activation (rsp_ch.activation),
   .rsp_derivative (rsp_ch.derivative),
   .rsp_net_sum    (rsp_ch.net_sum),
   .rsp_saturated  (rsp_ch.saturated)
);

// ===== verif/tb_neuron_sum_and_activation.sv =====
// ----------------------------------------------------------------------------
// tb_neuron_sum_and_activation
// Self-checking bench for the neuron block: drives store, fire, clear and
// unused requests with bursty valid and a stalling response ready, switches
// the activation mode over the APB port between idle phases, and compares
// every response field against a bit-accurate predictor in a scoreboard.
// ----------------------------------------------------------------------------
module tb_neuron_sum_and_activation;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          NUM_SLOTS   = nsa_pkg::NUM_CONNECTORS_DEF;
   localparam int          NUM_SEG     = nsa_pkg::SIGMOID_SEGMENTS_DEF;
   localparam logic [1:0]  REQ_UNUSED  = 2'd3;
   localparam int          QUIET_LIMIT = 1000;
   localparam int          SETTLE      = 40;
   localparam int          PHASE_ITEMS = 210;

   typedef struct packed {
      logic signed [nsa_pkg::VALUE_W-1:0] activation;
      logic [nsa_pkg::DER_W-1:0]          derivative;
      logic signed [nsa_pkg::VALUE_W-1:0] net_sum;
      logic                               saturated;
   } fire_result_type;

   class neuron_checker;
      nsa_pkg::mode_type  mode;
      logic signed [15:0] slot_val [NUM_SLOTS];
      bit                 slot_full [NUM_SLOTS];
      fire_result_type    expected_fires [$];
      int                 errors;

      function new();
         mode = nsa_pkg::MODE_SIGMOID;
         foreach (slot_full[i]) slot_full[i] = 1'b0;
         errors = 0;
      endfunction

      // sigmoid at 0.5*i, units of 1/65536
      function longint half_step(longint i);
         longint tbl [17];
         tbl = '{32768, 40793, 47911, 53580, 57724, 60565, 62428, 63615, 64357,
                 64816, 65097, 65269, 65374, 65438, 65476, 65500, 65514};
         return tbl[i];
      endfunction

      function longint fine_point(longint x);
         longint a;
         longint i;
         longint f;
         longint v;
         a = (x < 0) ? -x : x;
         if (a > 2048) a = 2048;
         i = a >>> 7;
         f = a & 127;
         if (i >= 16) begin
            v = half_step(16);
         end else begin
            v = half_step(i) + (((half_step(i + 1) - half_step(i)) * f + 64) >>> 7);
         end
         return (x < 0) ? 65536 - v : v;
      endfunction

      function longint sigmoid_q16(longint x);
         longint k;
         longint p0;
         longint p1;
         longint v0;
         longint v1;
         if (x < -2048) x = -2048;
         if (x > 2048) x = 2048;
         k = ((x + 2048) * NUM_SEG) / 4096;
         if (k > NUM_SEG - 1) k = NUM_SEG - 1;
         p0 = (4096 * k) / NUM_SEG - 2048;
         p1 = (4096 * (k + 1)) / NUM_SEG - 2048;
         v0 = fine_point(p0);
         v1 = fine_point(p1);
         if (p1 <= p0) return v0;
         return v0 + ((v1 - v0) * (x - p0)) / (p1 - p0);
      endfunction

      function fire_result_type fire_outcome();
         int              total;
         longint          g;
         fire_result_type r;
         total = 0;
         r.saturated = 1'b0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot_full[i]) total += slot_val[i];
         end
         if (total > 32767) begin
            total = 32767;
            r.saturated = 1'b1;
         end
         if (total < -32768) begin
            total = -32768;
            r.saturated = 1'b1;
         end
         r.net_sum = total[15:0];
         case (mode)
            nsa_pkg::MODE_IDENTITY: begin
               r.activation = total[15:0];
               r.derivative = 9'd256;
            end
            nsa_pkg::MODE_SIGMOID: begin
               g = sigmoid_q16(total);
               r.activation = 16'((g + 128) >>> 8);
               r.derivative = 9'((g * (65536 - g) + 64'sd8388608) >>> 24);
            end
            nsa_pkg::MODE_RAMP: begin
               if (total < 0) begin
                  r.activation = '0;
                  r.derivative = '0;
               end else begin
                  r.activation = 16'(total / 2);
                  r.derivative = 9'd128;
               end
            end
            default: begin
               r.activation = 16'(total >>> 1);
               r.derivative = 9'd128;
            end
         endcase
         return r;
      endfunction

      function void note_request(logic [1:0] kind, logic [2:0] conn,
                                 logic signed [15:0] value);
         case (kind)
            nsa_pkg::REQ_STORE: begin
               if (conn < NUM_SLOTS) begin
                  slot_val[conn]  = value;
                  slot_full[conn] = 1'b1;
               end
            end
            nsa_pkg::REQ_CLEAR: foreach (slot_full[i]) slot_full[i] = 1'b0;
            nsa_pkg::REQ_FIRE:  expected_fires.push_back(fire_outcome());
            default: ;
         endcase
      endfunction

      function void check_result(fire_result_type got);
         fire_result_type want;
         if (expected_fires.size() == 0) begin
            $display("%0t: unexpected response act=%0d der=%0d sum=%0d sat=%0b",
                     $time, got.activation, got.derivative, got.net_sum, got.saturated);
            errors++;
            return;
         end
         want = expected_fires.pop_front();
         if (got.activation !== want.activation) begin
            $display("%0t: activation expected %0d got %0d",
                     $time, want.activation, got.activation);
            errors++;
         end
         if (got.derivative !== want.derivative) begin
            $display("%0t: derivative expected %0d got %0d",
                     $time, want.derivative, got.derivative);
            errors++;
         end
         if (got.net_sum !== want.net_sum) begin
            $display("%0t: net_sum expected %0d got %0d", $time, want.net_sum, got.net_sum);
            errors++;
         end
         if (got.saturated !== want.saturated) begin
            $display("%0t: saturated expected %0b got %0b",
                     $time, want.saturated, got.saturated);
            errors++;
         end
      endfunction

      function int pending();
         return expected_fires.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   nsa_req_if req_bus ();
   nsa_rsp_if rsp_bus ();

   neuron_checker sb = new();
   int            burst_left = 0;

   neuron_sum_and_activation uut (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // response ready: random stalls, with stall-free stretches
   initial begin
      int stall_left;
      int cycle;
      stall_left = 0;
      cycle = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         cycle++;
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (((cycle / 400) % 4) != 3 && $urandom_range(0, 99) < 30)
               stall_left = $urandom_range(1, 24);
         end
      end
   end

   always @(posedge clock) begin
      if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
         sb.check_result('{activation: rsp_bus.activation, derivative: rsp_bus.derivative,
                           net_sum: rsp_bus.net_sum, saturated: rsp_bus.saturated});
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) ||
             (csr_psel === 1'b1 && csr_penable === 1'b1))
            quiet = 0;
         else
            quiet++;
      end
      $display("neuron_sum_and_activation verification failed");
      $finish;
   end

   task automatic push_request(input logic [1:0] kind, input logic [2:0] conn,
                               input logic signed [15:0] value);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_bus.valid       <= 1'b1;
      req_bus.req_type    <= kind;
      req_bus.connector   <= conn;
      req_bus.input_value <= value;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sb.note_request(kind, conn, value);
      @(negedge clock);
   endtask

   // let the block go idle, then write and read back the mode
   task automatic set_mode(input nsa_pkg::mode_type m);
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {nsa_pkg::REG_ACTIVATION_MODE, 2'b00};
      csr_pwdata  <= {30'd0, m};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      sb.mode = m;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata[1:0] !== m) begin
         $display("%0t: activation_mode readback expected %0d got %0d",
                  $time, m, csr_prdata[1:0]);
         sb.errors++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   function automatic logic signed [15:0] pick_value();
      logic signed [15:0] edges [5];
      edges = '{16'sh7fff, -16'sh8000, 16'sh0000, -16'sh0001, 16'sh0001};
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return 16'($signed($urandom_range(0, 512)) - 256);
         4, 5:       return 16'($signed($urandom_range(0, 1200)) - 600);
         6:          return edges[$urandom_range(0, 4)];
         default:    return 16'($urandom);
      endcase
   endfunction

   task automatic random_phase(input int count);
      int sent;
      int kind;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 99) < 85) begin
            if ($urandom_range(0, 4) == 0) begin
               push_request(nsa_pkg::REQ_CLEAR, 3'($urandom), 16'($urandom));
               sent++;
            end
            repeat ($urandom_range(1, 8)) begin
               push_request(nsa_pkg::REQ_STORE, 3'($urandom_range(0, 7)), pick_value());
               sent++;
            end
            push_request(nsa_pkg::REQ_FIRE, 3'($urandom), 16'($urandom));
            sent++;
            if ($urandom_range(0, 5) == 0) begin
               push_request(nsa_pkg::REQ_FIRE, 3'($urandom), 16'($urandom));
               sent++;
            end
         end else begin
            kind = $urandom_range(0, 3);
            push_request(2'(kind), 3'($urandom), pick_value());
            if (kind != REQ_UNUSED) sent++;
         end
      end
   endtask

   initial begin
      nsa_pkg::mode_type order [8];
      reset               = 1'b1;
      csr_psel            = 1'b0;
      csr_penable         = 1'b0;
      csr_pwrite          = 1'b0;
      csr_paddr           = '0;
      csr_pwdata          = '0;
      req_bus.valid       = 1'b0;
      req_bus.req_type    = nsa_pkg::REQ_STORE;
      req_bus.connector   = '0;
      req_bus.input_value = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed, reset mode (sigmoid)
      push_request(nsa_pkg::REQ_FIRE, 3'd0, 16'sd0);
      push_request(REQ_UNUSED, 3'd7, -16'sd1);
      push_request(nsa_pkg::REQ_STORE, 3'd0, 16'sh7fff);
      push_request(nsa_pkg::REQ_STORE, 3'd1, 16'sh7fff);
      push_request(nsa_pkg::REQ_FIRE, 3'd0, 16'sd0);
      push_request(nsa_pkg::REQ_STORE, 3'd0, -16'sh8000);
      push_request(nsa_pkg::REQ_STORE, 3'd1, -16'sh8000);
      push_request(nsa_pkg::REQ_FIRE, 3'd7, -16'sd1);
      push_request(nsa_pkg::REQ_CLEAR, 3'd5, 16'sh5555);
      push_request(nsa_pkg::REQ_FIRE, 3'd2, 16'sh2aaa);
      push_request(nsa_pkg::REQ_STORE, 3'd7, 16'sd2048);
      push_request(nsa_pkg::REQ_FIRE, 3'd0, 16'sd0);
      push_request(nsa_pkg::REQ_STORE, 3'd7, -16'sd2048);
      push_request(nsa_pkg::REQ_FIRE, 3'd0, 16'sd0);
      push_request(nsa_pkg::REQ_STORE, 3'd7, 16'sd1);
      push_request(nsa_pkg::REQ_FIRE, 3'd0, 16'sd0);
      push_request(nsa_pkg::REQ_STORE, 3'd6, -16'sd2);
      push_request(nsa_pkg::REQ_FIRE, 3'd0, 16'sd0);
      push_request(nsa_pkg::REQ_STORE, 3'd3, 16'sd256);
      push_request(nsa_pkg::REQ_FIRE, 3'd0, 16'sd0);
      push_request(REQ_UNUSED, 3'd0, 16'sd0);
      push_request(nsa_pkg::REQ_CLEAR, 3'd0, 16'sd0);

      order = '{nsa_pkg::MODE_IDENTITY, nsa_pkg::MODE_LINEAR,
                nsa_pkg::MODE_RAMP, nsa_pkg::MODE_SIGMOID,
                nsa_pkg::mode_type'($urandom_range(0, 3)),
                nsa_pkg::mode_type'($urandom_range(0, 3)),
                nsa_pkg::mode_type'($urandom_range(0, 3)),
                nsa_pkg::mode_type'($urandom_range(0, 3))};
      foreach (order[p]) begin
         set_mode(order[p]);
         random_phase(PHASE_ITEMS);
      end

      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
      if (sb.errors == 0)
         $display("neuron_sum_and_activation verification clean");
      else
         $display("neuron_sum_and_activation verification failed");
      $finish;
   end

endmodule
